// File: src/cfs_pkg.sv
package cfs_pkg;

   localparam int MaxSlots        = 4;
   localparam int NumSlotsDefault = 4;
   localparam int PayloadBytes    = 8;
   localparam int IdW             = 11;
   localparam int FrameIdW        = 29;
   localparam int PeriodW         = 16;
   localparam int CkLayW          = 4;
   localparam int CntLayW         = 7;
   localparam int MultW           = 8;
   localparam int ThrW            = PeriodW + MultW;
   localparam int TimeW           = 32;
   localparam int CounterW        = 4;
   localparam int CsrIdxW         = 3;
   localparam int CsrDataW        = 64;
   localparam int MaxResults      = 4;
   localparam int ResIdxW         = $clog2(MaxResults);
   localparam int ResCntW         = ResIdxW + 1;
   localparam logic [MultW-1:0] MultReset = 8'd8;

   localparam logic [CsrIdxW-1:0] CSR_SLOT_ENABLE     = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_MESSAGE_IDS     = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_PERIODS         = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_CHECKSUM_LAYOUT = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_COUNTER_LAYOUT  = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_TIMEOUT_MULT    = 3'd5;

   localparam logic REQ_FRAME = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   typedef enum logic [1:0] {
      KIND_COUNTER_GAP,
      KIND_CHECKSUM,
      KIND_UNKNOWN_ID,
      KIND_TIMEOUT
   } cfs_kind_type;

   typedef struct packed {
      logic        req_type;
      logic [28:0] frame_id;
      logic [63:0] payload;
      logic [31:0] time_ms;
   } cfs_req_type;

   typedef struct packed {
      cfs_kind_type anomaly_kind;
      logic [28:0]  anomaly_id;
      logic [7:0]   expected_value;
      logic [7:0]   received_value;
      logic [31:0]  elapsed_ms;
      logic         never_seen;
      logic [31:0]  event_time_ms;
      logic         last_result;
   } cfs_rsp_type;

   // what one slot lane reports to the merge stage
   typedef struct packed {
      logic                match;
      logic                cnt_err;
      logic                ck_err;
      logic [CounterW-1:0] exp_cnt;
      logic [CounterW-1:0] got_cnt;
      logic [7:0]          calc_ck;
      logic [7:0]          got_ck;
      logic                tmo;
      logic                never;
      logic [TimeW-1:0]    elapsed;
      logic [IdW-1:0]      slot_id;
   } cfs_find_type;

endpackage

// File: src/cfs_lane.sv
module cfs_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic                          win,
   input  logic                          slot_en,
   input  logic [cfs_pkg::IdW-1:0]       slot_id,
   input  logic [cfs_pkg::PeriodW-1:0]   slot_period,
   input  logic [cfs_pkg::MultW-1:0]     mult_q,
   input  logic [cfs_pkg::CkLayW-1:0]    ck_lay,
   input  logic [cfs_pkg::CntLayW-1:0]   cnt_lay,
   input  cfs_pkg::cfs_req_type          req,
   output cfs_pkg::cfs_find_type         find
);

   logic [cfs_pkg::ThrW-1:0]     thr;
   logic [cfs_pkg::CounterW-1:0] prev_ff, prev_in;
   logic                         cval_ff, cval_in;
   logic [cfs_pkg::TimeW-1:0]    last_ff, last_in;
   logic                         seen_ff, seen_in;
   logic                         tflag_ff, tflag_in;

   logic [7:0]                   cnt_byte;
   logic [7:0]                   cnt_shift;
   logic [cfs_pkg::CounterW-1:0] cnt_val;
   logic [cfs_pkg::CounterW-1:0] exp_cnt;
   logic [7:0]                   xor_all;
   logic [7:0]                   got_ck;
   logic [7:0]                   calc_ck;
   logic                         early;
   logic [cfs_pkg::TimeW-1:0]    elapsed;
   logic                         tout;
   logic                         is_frame;
   logic                         is_tick;

   // threshold in quarter-ms
   assign thr = cfs_pkg::ThrW'(slot_period) * cfs_pkg::ThrW'(mult_q);

   assign cnt_byte  = req.payload[{cnt_lay[5:3], 3'b000} +: 8];
   assign cnt_shift = cnt_byte >> cnt_lay[2:0];
   assign cnt_val   = cnt_shift[cfs_pkg::CounterW-1:0];
   assign exp_cnt   = prev_ff + cfs_pkg::CounterW'(1);

   always_comb begin
      xor_all = '0;
      for (int i = 0; i < cfs_pkg::PayloadBytes; i++) begin
         xor_all = xor_all ^ req.payload[i*8 +: 8];
      end
   end

   assign got_ck  = req.payload[{ck_lay[2:0], 3'b000} +: 8];
   // XOR of the other seven bytes
   assign calc_ck = xor_all ^ got_ck;

   assign early   = req.time_ms < last_ff;
   assign elapsed = !seen_ff ? '1 : (early ? '0 : req.time_ms - last_ff);
   assign tout    = !seen_ff ||
                    (!early && ({elapsed, 2'b00} > {10'b0, thr}));

   assign is_frame = req.req_type == cfs_pkg::REQ_FRAME;
   assign is_tick  = req.req_type == cfs_pkg::REQ_TICK;

   always_comb begin
      find         = '0;
      find.match   = slot_en && (req.frame_id == {18'b0, slot_id});
      find.cnt_err = cnt_lay[6] && cval_ff && (cnt_val != exp_cnt);
      find.ck_err  = ck_lay[3] && (calc_ck != got_ck);
      find.exp_cnt = exp_cnt;
      find.got_cnt = cnt_val;
      find.calc_ck = calc_ck;
      find.got_ck  = got_ck;
      find.tmo     = slot_en && tout && !tflag_ff;
      find.never   = !seen_ff;
      find.elapsed = elapsed;
      find.slot_id = slot_id;
   end

   always_comb begin
      prev_in  = prev_ff;
      cval_in  = cval_ff;
      last_in  = last_ff;
      seen_in  = seen_ff;
      tflag_in = tflag_ff;
      if (go && is_frame && win) begin
         if (cnt_lay[6]) begin
            prev_in = cnt_val;
            cval_in = 1'b1;
         end
         last_in  = req.time_ms;
         seen_in  = 1'b1;
         tflag_in = 1'b0;
      end else if (go && is_tick && slot_en) begin
         tflag_in = tout;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         cval_ff  <= 1'b0;
         last_ff  <= '0;
         seen_ff  <= 1'b0;
         tflag_ff <= 1'b0;
      end else begin
         prev_ff  <= prev_in;
         cval_ff  <= cval_in;
         last_ff  <= last_in;
         seen_ff  <= seen_in;
         tflag_ff <= tflag_in;
      end
   end

endmodule

// File: src/cfs_merge.sv
module cfs_merge #(
   parameter int NUM_SLOTS = cfs_pkg::NumSlotsDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 go,
   input  cfs_pkg::cfs_req_type                 req,
   input  cfs_pkg::cfs_find_type [NUM_SLOTS-1:0] find,
   output logic [NUM_SLOTS-1:0]                 win,
   output logic                                 done,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output cfs_pkg::cfs_rsp_type                 rsp_data
);

   cfs_pkg::cfs_rsp_type        list [cfs_pkg::MaxResults];
   logic [cfs_pkg::ResCntW-1:0] n;
   logic                        found;

   cfs_pkg::cfs_rsp_type        buf_ff [cfs_pkg::MaxResults];
   cfs_pkg::cfs_rsp_type        buf_in [cfs_pkg::MaxResults];
   logic [cfs_pkg::ResCntW-1:0] cnt_ff, cnt_in;
   logic [cfs_pkg::ResCntW-1:0] idx_ff, idx_in;
   logic                        pend_ff, pend_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   cfs_pkg::cfs_rsp_type        rsp_data_ff, rsp_data_in;

   logic                        load_out;
   logic                        last;

   // lowest enabled slot with a matching id wins
   always_comb begin
      found = 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         win[s] = find[s].match && !found;
         found  = found || find[s].match;
      end
   end

   always_comb begin
      for (int i = 0; i < cfs_pkg::MaxResults; i++) begin
         list[i] = '0;
         list[i].event_time_ms = req.time_ms;
      end
      n = '0;
      if (req.req_type == cfs_pkg::REQ_FRAME) begin
         if (!found) begin
            list[0].anomaly_kind = cfs_pkg::KIND_UNKNOWN_ID;
            list[0].anomaly_id   = req.frame_id;
            n = cfs_pkg::ResCntW'(1);
         end else begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
               if (win[s] && find[s].cnt_err) begin
                  list[n[cfs_pkg::ResIdxW-1:0]].anomaly_kind   = cfs_pkg::KIND_COUNTER_GAP;
                  list[n[cfs_pkg::ResIdxW-1:0]].anomaly_id     = req.frame_id;
                  list[n[cfs_pkg::ResIdxW-1:0]].expected_value = {4'b0, find[s].exp_cnt};
                  list[n[cfs_pkg::ResIdxW-1:0]].received_value = {4'b0, find[s].got_cnt};
                  n = n + cfs_pkg::ResCntW'(1);
               end
               if (win[s] && find[s].ck_err) begin
                  list[n[cfs_pkg::ResIdxW-1:0]].anomaly_kind   = cfs_pkg::KIND_CHECKSUM;
                  list[n[cfs_pkg::ResIdxW-1:0]].anomaly_id     = req.frame_id;
                  list[n[cfs_pkg::ResIdxW-1:0]].expected_value = find[s].calc_ck;
                  list[n[cfs_pkg::ResIdxW-1:0]].received_value = find[s].got_ck;
                  n = n + cfs_pkg::ResCntW'(1);
               end
            end
         end
      end else begin
         for (int s = 0; s < NUM_SLOTS; s++) begin
            if (find[s].tmo) begin
               list[n[cfs_pkg::ResIdxW-1:0]].anomaly_kind = cfs_pkg::KIND_TIMEOUT;
               list[n[cfs_pkg::ResIdxW-1:0]].anomaly_id   = {18'b0, find[s].slot_id};
               list[n[cfs_pkg::ResIdxW-1:0]].elapsed_ms   = find[s].elapsed;
               list[n[cfs_pkg::ResIdxW-1:0]].never_seen   = find[s].never;
               n = n + cfs_pkg::ResCntW'(1);
            end
         end
      end
   end

   assign load_out = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign last     = (idx_ff + cfs_pkg::ResCntW'(1)) == cnt_ff;
   assign done     = (go && (n == '0)) || (load_out && last);

   always_comb begin
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (go) begin
         buf_in  = list;
         cnt_in  = n;
         idx_in  = '0;
         pend_in = n != '0;
      end else if (load_out) begin
         idx_in  = idx_ff + cfs_pkg::ResCntW'(1);
         pend_in = !last;
      end
      if (load_out) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in             = buf_ff[idx_ff[cfs_pkg::ResIdxW-1:0]];
         rsp_data_in.last_result = last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff      <= buf_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/can_frame_supervisor_core.sv
// CAN frame supervisor: checks alive counter, XOR checksum and reception timeout for up
// to NUM_SLOTS configured standard ids. One item is in work at a time. An accepted item
// is registered, evaluated by all slot lanes in parallel in the next cycle, and its
// anomalies (zero to four) leave through the output register one per cycle while
// rsp_ready is high; req_ready rises again as the last result enters the output
// register, or after the evaluation cycle if there is none. Write configuration only
// while no item is in flight.
module can_frame_supervisor_core #(
   parameter int NUM_SLOTS = cfs_pkg::NumSlotsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cfs_pkg::cfs_req_type          req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output cfs_pkg::cfs_rsp_type          rsp_data,
   input  logic                          csr_we,
   input  logic [cfs_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [cfs_pkg::CsrDataW-1:0]  csr_wdata
);

   logic [cfs_pkg::MaxSlots-1:0]            slot_enable_ff, slot_enable_in;
   logic [cfs_pkg::MaxSlots*cfs_pkg::IdW-1:0]     message_ids_ff, message_ids_in;
   logic [cfs_pkg::MaxSlots*cfs_pkg::PeriodW-1:0] periods_ff, periods_in;
   logic [cfs_pkg::MaxSlots*cfs_pkg::CkLayW-1:0]  ck_layout_ff, ck_layout_in;
   logic [cfs_pkg::MaxSlots*cfs_pkg::CntLayW-1:0] cnt_layout_ff, cnt_layout_in;
   logic [cfs_pkg::MultW-1:0]               mult_ff, mult_in;

   cfs_pkg::cfs_req_type                    req_ff, req_in;
   logic                                    go_ff, go_in;
   logic                                    busy_ff, busy_in;
   logic                                    accept;

   cfs_pkg::cfs_find_type [NUM_SLOTS-1:0]   find;
   logic [NUM_SLOTS-1:0]                    win;
   logic                                    done;

   always_comb begin
      slot_enable_in = slot_enable_ff;
      message_ids_in = message_ids_ff;
      periods_in     = periods_ff;
      ck_layout_in   = ck_layout_ff;
      cnt_layout_in  = cnt_layout_ff;
      mult_in        = mult_ff;
      if (csr_we) begin
         unique case (csr_index)
            cfs_pkg::CSR_SLOT_ENABLE:     slot_enable_in = csr_wdata[cfs_pkg::MaxSlots-1:0];
            cfs_pkg::CSR_MESSAGE_IDS:
               message_ids_in = csr_wdata[cfs_pkg::MaxSlots*cfs_pkg::IdW-1:0];
            cfs_pkg::CSR_PERIODS:
               periods_in = csr_wdata[cfs_pkg::MaxSlots*cfs_pkg::PeriodW-1:0];
            cfs_pkg::CSR_CHECKSUM_LAYOUT:
               ck_layout_in = csr_wdata[cfs_pkg::MaxSlots*cfs_pkg::CkLayW-1:0];
            cfs_pkg::CSR_COUNTER_LAYOUT:
               cnt_layout_in = csr_wdata[cfs_pkg::MaxSlots*cfs_pkg::CntLayW-1:0];
            cfs_pkg::CSR_TIMEOUT_MULT:    mult_in = csr_wdata[cfs_pkg::MultW-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign go_in     = accept;
   assign req_in    = accept ? req_data : req_ff;

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      if (reset) begin
         slot_enable_ff <= '0;
         message_ids_ff <= '0;
         periods_ff     <= '0;
         ck_layout_ff   <= '0;
         cnt_layout_ff  <= '0;
         mult_ff        <= cfs_pkg::MultReset;
         go_ff          <= 1'b0;
         busy_ff        <= 1'b0;
      end else begin
         slot_enable_ff <= slot_enable_in;
         message_ids_ff <= message_ids_in;
         periods_ff     <= periods_in;
         ck_layout_ff   <= ck_layout_in;
         cnt_layout_ff  <= cnt_layout_in;
         mult_ff        <= mult_in;
         go_ff          <= go_in;
         busy_ff        <= busy_in;
      end
   end

   for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_lane
      cfs_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .go          (go_ff),
         .win         (win[s]),
         .slot_en     (slot_enable_ff[s]),
         .slot_id     (message_ids_ff[s*cfs_pkg::IdW +: cfs_pkg::IdW]),
         .slot_period (periods_ff[s*cfs_pkg::PeriodW +: cfs_pkg::PeriodW]),
         .mult_q      (mult_ff),
         .ck_lay      (ck_layout_ff[s*cfs_pkg::CkLayW +: cfs_pkg::CkLayW]),
         .cnt_lay     (cnt_layout_ff[s*cfs_pkg::CntLayW +: cfs_pkg::CntLayW]),
         .req         (req_ff),
         .find        (find[s])
      );
   end

   cfs_merge #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .go        (go_ff),
      .req       (req_ff),
      .find      (find),
      .win       (win),
      .done      (done),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: src/cfs_checker.sv
module cfs_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input cfs_pkg::cfs_rsp_type rsp_data
);

   // a stalled result transfer holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one item at a time: no second transfer right after an accepted one
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while busy");

   a_tmo_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.anomaly_kind == cfs_pkg::KIND_TIMEOUT
      |-> rsp_data.anomaly_id[28:11] == '0)
      else $error("timeout id outside the standard range");

   a_frame_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.anomaly_kind != cfs_pkg::KIND_TIMEOUT
      |-> rsp_data.elapsed_ms == '0 && !rsp_data.never_seen)
      else $error("timeout fields set on a frame anomaly");

   a_never_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.never_seen |-> rsp_data.elapsed_ms == '1)
      else $error("never-seen timeout without saturated elapsed time");

endmodule

bind can_frame_supervisor_core cfs_checker u_cfs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: test/tb_can_frame_supervisor_core.sv
module tb_can_frame_supervisor_core;

   localparam logic [cfs_pkg::CsrIdxW-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [cfs_pkg::CsrIdxW-1:0] CSR_SPARE_7 = 3'd7;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   cfs_pkg::cfs_req_type         req_data = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   cfs_pkg::cfs_rsp_type         rsp_data;
   logic                         csr_we = 1'b0;
   logic [cfs_pkg::CsrIdxW-1:0]  csr_index = '0;
   logic [cfs_pkg::CsrDataW-1:0] csr_wdata = '0;

   can_frame_supervisor_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register copies, shared by the predictor and the frame generator
   logic [3:0]  cfg_enable      = '0;
   logic [43:0] cfg_ids         = '0;
   logic [63:0] cfg_periods     = '0;
   logic [15:0] cfg_ck_layout   = '0;
   logic [27:0] cfg_cnt_layout  = '0;
   logic [7:0]  cfg_mult        = cfs_pkg::MultReset;

   // per-slot supervision state
   logic [3:0]  prev_cnt  [cfs_pkg::MaxSlots];
   logic        cnt_valid [cfs_pkg::MaxSlots];
   logic [31:0] last_seen [cfs_pkg::MaxSlots];
   logic        seen      [cfs_pkg::MaxSlots];
   logic        tmo_flag  [cfs_pkg::MaxSlots];

   logic [3:0]  gen_cnt   [cfs_pkg::MaxSlots];

   cfs_pkg::cfs_req_type pending_items[$];
   cfs_pkg::cfs_rsp_type expected_anomalies[$];

   int   queued_count   = 0;
   int   accepted_count = 0;
   int   anomaly_count  = 0;
   int   error_count    = 0;
   int   kind_hits [4];
   int   send_idle_pct  = 0;
   int   recv_idle_pct  = 0;
   logic stall_request  = 1'b0;
   logic long_hold      = 1'b0;
   logic next_offer;

   initial begin
      for (int s = 0; s < cfs_pkg::MaxSlots; s++) begin
         prev_cnt[s]  = '0;
         cnt_valid[s] = 1'b0;
         last_seen[s] = '0;
         seen[s]      = 1'b0;
         tmo_flag[s]  = 1'b0;
         gen_cnt[s]   = '0;
      end
      for (int k = 0; k < 4; k++) kind_hits[k] = 0;
   end

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [28:0] slot_id(input int s);
      return {18'd0, cfg_ids[11*s +: 11]};
   endfunction

   function automatic cfs_pkg::cfs_rsp_type make_anomaly(input cfs_pkg::cfs_kind_type kind,
                                                         input logic [28:0] id,
                                                         input logic [7:0] want,
                                                         input logic [7:0] got,
                                                         input logic [31:0] elapsed,
                                                         input logic never,
                                                         input logic [31:0] stamp);
      cfs_pkg::cfs_rsp_type a;
      a.anomaly_kind   = kind;
      a.anomaly_id     = id;
      a.expected_value = want;
      a.received_value = got;
      a.elapsed_ms     = elapsed;
      a.never_seen     = never;
      a.event_time_ms  = stamp;
      a.last_result    = 1'b0;
      return a;
   endfunction

   function automatic void predict_anomalies(input cfs_pkg::cfs_req_type item);
      cfs_pkg::cfs_rsp_type found [cfs_pkg::MaxResults];
      int          n;
      int          hit;
      logic [6:0]  cl;
      logic [3:0]  ck;
      logic [7:0]  shifted;
      logic [7:0]  sum;
      logic [7:0]  got;
      logic [3:0]  cnt;
      logic [3:0]  want;
      logic [23:0] thr4;
      logic [31:0] elapsed;
      logic [33:0] el4;
      logic        tout;
      n   = 0;
      hit = -1;
      if (item.req_type == cfs_pkg::REQ_FRAME) begin
         // lowest enabled slot wins; ids of 2048 and up never compare equal
         for (int s = 0; s < cfs_pkg::MaxSlots; s++) begin
            if (hit < 0 && cfg_enable[s] && item.frame_id == slot_id(s)) hit = s;
         end
         if (hit < 0) begin
            found[0] = make_anomaly(cfs_pkg::KIND_UNKNOWN_ID, item.frame_id, 8'd0, 8'd0,
                                    32'd0, 1'b0, item.time_ms);
            n = 1;
         end else begin
            cl = cfg_cnt_layout[7*hit +: 7];
            if (cl[6]) begin
               // bits shifted past the top of the byte read as zero
               shifted = item.payload[8*cl[5:3] +: 8] >> cl[2:0];
               cnt     = shifted[3:0];
               if (cnt_valid[hit]) begin
                  want = prev_cnt[hit] + 4'd1;
                  if (cnt != want) begin
                     found[n] = make_anomaly(cfs_pkg::KIND_COUNTER_GAP, item.frame_id,
                                             {4'd0, want}, {4'd0, cnt}, 32'd0, 1'b0,
                                             item.time_ms);
                     n++;
                  end
               end
               prev_cnt[hit]  = cnt;
               cnt_valid[hit] = 1'b1;
            end
            ck = cfg_ck_layout[4*hit +: 4];
            if (ck[3]) begin
               sum = '0;
               for (int i = 0; i < cfs_pkg::PayloadBytes; i++) begin
                  if (i != ck[2:0]) sum ^= item.payload[8*i +: 8];
               end
               got = item.payload[8*ck[2:0] +: 8];
               if (sum != got) begin
                  found[n] = make_anomaly(cfs_pkg::KIND_CHECKSUM, item.frame_id, sum, got,
                                          32'd0, 1'b0, item.time_ms);
                  n++;
               end
            end
            last_seen[hit] = item.time_ms;
            seen[hit]      = 1'b1;
            tmo_flag[hit]  = 1'b0;
         end
      end else begin
         for (int s = 0; s < cfs_pkg::MaxSlots; s++) begin
            if (cfg_enable[s]) begin
               thr4 = cfg_periods[16*s +: 16] * cfg_mult;
               if (!seen[s]) begin
                  elapsed = 32'hFFFF_FFFF;
                  tout    = 1'b1;
               end else if (item.time_ms < last_seen[s]) begin
                  elapsed = '0;
                  tout    = 1'b0;
               end else begin
                  elapsed = item.time_ms - last_seen[s];
                  el4     = {elapsed, 2'b00};
                  tout    = el4 > {10'd0, thr4};
               end
               // report only on the rising edge of the timed-out condition
               if (tout && !tmo_flag[s]) begin
                  found[n] = make_anomaly(cfs_pkg::KIND_TIMEOUT, slot_id(s), 8'd0, 8'd0,
                                          elapsed, !seen[s], item.time_ms);
                  n++;
               end
               tmo_flag[s] = tout;
            end
         end
      end
      if (n > 0) found[n-1].last_result = 1'b1;
      for (int k = 0; k < n; k++) expected_anomalies = {expected_anomalies, found[k]};
   endfunction

   function automatic void note_failure(input string what);
      error_count++;
      if (error_count <= 10) $display("%s", what);
   endfunction

   function automatic string fmt_anomaly(input cfs_pkg::cfs_rsp_type a);
      return $sformatf("k=%0d id=%h ev=%h rv=%h el=%h ns=%b t=%h l=%b",
                       a.anomaly_kind, a.anomaly_id, a.expected_value, a.received_value,
                       a.elapsed_ms, a.never_seen, a.event_time_ms, a.last_result);
   endfunction

   // driver: one transfer per handshake, valid held until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_offer = req_valid;
         if (req_valid && req_ready) begin
            predict_anomalies(req_data);
            accepted_count++;
            next_offer = 1'b0;
         end
         if (!next_offer && pending_items.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            req_data <= pending_items.pop_front();
            next_offer = 1'b1;
         end
         req_valid <= next_offer;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !long_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      cfs_pkg::cfs_rsp_type want;
      string       bad;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_anomalies.size() == 0) begin
            note_failure($sformatf("unexpected anomaly transfer: kind=%0d id=%h",
                                   rsp_data.anomaly_kind, rsp_data.anomaly_id));
         end else begin
            want = expected_anomalies.pop_front();
            anomaly_count++;
            kind_hits[want.anomaly_kind]++;
            bad = "";
            if (rsp_data.anomaly_kind !== want.anomaly_kind)     bad = {bad, " kind"};
            if (rsp_data.anomaly_id !== want.anomaly_id)         bad = {bad, " id"};
            if (rsp_data.expected_value !== want.expected_value) bad = {bad, " expected"};
            if (rsp_data.received_value !== want.received_value) bad = {bad, " received"};
            if (rsp_data.elapsed_ms !== want.elapsed_ms)         bad = {bad, " elapsed"};
            if (rsp_data.never_seen !== want.never_seen)         bad = {bad, " never_seen"};
            if (rsp_data.event_time_ms !== want.event_time_ms)   bad = {bad, " time"};
            if (rsp_data.last_result !== want.last_result)       bad = {bad, " last"};
            if (bad != "") begin
               note_failure($sformatf("anomaly %0d mismatch in%s: exp %s, got %s",
                                      anomaly_count, bad, fmt_anomaly(want),
                                      fmt_anomaly(rsp_data)));
            end
         end
      end
   end

   function automatic void queue_req(input logic kind, input logic [28:0] fid,
                                     input logic [63:0] pl, input logic [31:0] stamp);
      cfs_pkg::cfs_req_type item;
      item.req_type = kind;
      item.frame_id = fid;
      item.payload  = pl;
      item.time_ms  = stamp;
      pending_items = {pending_items, item};
      queued_count++;
   endfunction

   // random frame for slot s carrying counter cnt, with the checksum byte fixed up unless spoil is set
   function automatic logic [63:0] frame_for_slot(input int s, input logic [3:0] cnt,
                                                  input logic spoil);
      logic [63:0] pl;
      logic [6:0]  cl;
      logic [3:0]  ck;
      logic [7:0]  sum;
      pl = {$urandom, $urandom};
      cl = cfg_cnt_layout[7*s +: 7];
      for (int k = 0; k < 4; k++) begin
         if (cl[2:0] + k < 8) pl[8*cl[5:3] + cl[2:0] + k] = cnt[k];
      end
      ck  = cfg_ck_layout[4*s +: 4];
      sum = '0;
      for (int i = 0; i < cfs_pkg::PayloadBytes; i++) begin
         if (i != ck[2:0]) sum ^= pl[8*i +: 8];
      end
      pl[8*ck[2:0] +: 8] = sum ^ (spoil ? 8'($urandom_range(255, 1)) : 8'd0);
      return pl;
   endfunction

   task automatic write_csr(input logic [cfs_pkg::CsrIdxW-1:0] idx,
                            input logic [cfs_pkg::CsrDataW-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         cfs_pkg::CSR_SLOT_ENABLE:     cfg_enable     = value[3:0];
         cfs_pkg::CSR_MESSAGE_IDS:     cfg_ids        = value[43:0];
         cfs_pkg::CSR_PERIODS:         cfg_periods    = value;
         cfs_pkg::CSR_CHECKSUM_LAYOUT: cfg_ck_layout  = value[15:0];
         cfs_pkg::CSR_COUNTER_LAYOUT:  cfg_cnt_layout = value[27:0];
         cfs_pkg::CSR_TIMEOUT_MULT:    cfg_mult       = value[7:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // every queued item accepted and every anomaly seen, then room for a
   // fault-free frame still in the pipe
   task automatic wait_until_drained();
      while (accepted_count != queued_count || expected_anomalies.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic run_random_phase(input int n_items, input logic [31:0] start_ms);
      int          pick;
      int          s;
      logic [31:0] now_ms;
      now_ms = start_ms;
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(99);
         do s = $urandom_range(cfs_pkg::MaxSlots - 1);
         while (cfg_enable != 0 && !cfg_enable[s]);
         if (pick < 55) begin
            if ($urandom_range(19) == 0) gen_cnt[s] = 4'($urandom);
            now_ms += $urandom_range(12);
            queue_req(cfs_pkg::REQ_FRAME, slot_id(s),
                      frame_for_slot(s, gen_cnt[s], $urandom_range(11) == 0), now_ms);
            gen_cnt[s] += 4'd1;
         end else if (pick < 72) begin
            now_ms += $urandom_range(30);
            queue_req(cfs_pkg::REQ_TICK, 29'($urandom), {$urandom, $urandom}, now_ms);
         end else if (pick < 80) begin
            queue_req(cfs_pkg::REQ_TICK, 29'($urandom), {$urandom, $urandom}, $urandom);
         end else if (pick < 90) begin
            queue_req(cfs_pkg::REQ_FRAME,
                      $urandom_range(1) ? 29'($urandom) : 29'($urandom_range(2047)),
                      {$urandom, $urandom}, now_ms);
         end else begin
            queue_req(cfs_pkg::REQ_FRAME, slot_id(s), {$urandom, $urandom}, now_ms);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset         <= 1'b0;
      send_idle_pct <= 29;
      recv_idle_pct <= 51;

      // reset configuration: nothing enabled
      queue_req(cfs_pkg::REQ_TICK, 29'd0, 64'd0, 32'd0);
      queue_req(cfs_pkg::REQ_FRAME, 29'h123, 64'h0123_4567_89AB_CDEF, 32'd3);
      wait_until_drained();

      // slot 3 shares slot 0's id and must never win
      write_csr(cfs_pkg::CSR_SLOT_ENABLE, 64'hF);
      write_csr(cfs_pkg::CSR_MESSAGE_IDS, 64'({11'h123, 11'h000, 11'h7FF, 11'h123}));
      write_csr(cfs_pkg::CSR_PERIODS, {16'd5, 16'd0, 16'hFFFF, 16'd10});
      write_csr(cfs_pkg::CSR_CHECKSUM_LAYOUT, 64'({4'hB, 4'h0, 4'h8, 4'hF}));
      write_csr(cfs_pkg::CSR_COUNTER_LAYOUT, 64'({7'h00, 7'h5D, 7'h7F, 7'h40}));
      write_csr(cfs_pkg::CSR_TIMEOUT_MULT, 64'(cfs_pkg::MultReset));

      queue_req(cfs_pkg::REQ_TICK, 29'd0, 64'd0, 32'd0);
      queue_req(cfs_pkg::REQ_TICK, 29'h1FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
      queue_req(cfs_pkg::REQ_FRAME, 29'h123, frame_for_slot(0, 4'd3, 1'b0), 32'd100);
      queue_req(cfs_pkg::REQ_FRAME, 29'h123, frame_for_slot(0, 4'd5, 1'b1), 32'd105);
      queue_req(cfs_pkg::REQ_FRAME, 29'h123, frame_for_slot(0, 4'd6, 1'b0), 32'd110);
      queue_req(cfs_pkg::REQ_FRAME, 29'h7FF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd111);
      queue_req(cfs_pkg::REQ_FRAME, 29'h7FF, 64'd0, 32'd112);
      queue_req(cfs_pkg::REQ_FRAME, 29'h000, {$urandom, $urandom}, 32'd113);
      queue_req(cfs_pkg::REQ_FRAME, 29'h000, {$urandom, $urandom}, 32'd113);
      queue_req(cfs_pkg::REQ_FRAME, 29'h800, 64'd0, 32'd114);
      queue_req(cfs_pkg::REQ_FRAME, 29'h1FFF_FFFF, 64'd0, 32'd115);
      queue_req(cfs_pkg::REQ_TICK, 29'd0, 64'd0, 32'd130);
      queue_req(cfs_pkg::REQ_TICK, 29'd0, 64'd0, 32'd131);
      queue_req(cfs_pkg::REQ_TICK, 29'd0, 64'd0, 32'd50);
      queue_req(cfs_pkg::REQ_TICK, 29'd0, 64'd0, 32'hFFFF_FFFF);
      queue_req(cfs_pkg::REQ_FRAME, 29'h123, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      queue_req(cfs_pkg::REQ_FRAME, 29'h123, 64'd0, 32'd0);
      wait_until_drained();

      write_csr(cfs_pkg::CSR_MESSAGE_IDS, {$urandom, $urandom});
      write_csr(cfs_pkg::CSR_PERIODS, {16'($urandom_range(40, 1)), 16'($urandom_range(40, 1)),
                                       16'($urandom_range(40, 1)), 16'($urandom_range(40, 1))});
      write_csr(cfs_pkg::CSR_CHECKSUM_LAYOUT, 64'($urandom) | 64'h8888);
      write_csr(cfs_pkg::CSR_COUNTER_LAYOUT, 64'($urandom) | 64'h810_2040);
      write_csr(cfs_pkg::CSR_TIMEOUT_MULT, 64'd1);
      run_random_phase(150, 32'd0);
      wait_until_drained();

      send_idle_pct <= 51;
      recv_idle_pct <= 29;
      write_csr(CSR_SPARE_6, {$urandom, $urandom});
      write_csr(CSR_SPARE_7, {$urandom, $urandom});
      write_csr(cfs_pkg::CSR_SLOT_ENABLE, 64'($urandom_range(15, 1)));
      write_csr(cfs_pkg::CSR_MESSAGE_IDS,
                64'({11'($urandom), 11'($urandom), 11'h0AA, 11'h0AA}));
      write_csr(cfs_pkg::CSR_PERIODS, {16'($urandom_range(40)), 16'($urandom_range(40)),
                                       16'd0, 16'hFFFF});
      write_csr(cfs_pkg::CSR_CHECKSUM_LAYOUT, 64'($urandom));
      write_csr(cfs_pkg::CSR_COUNTER_LAYOUT, 64'($urandom));
      write_csr(cfs_pkg::CSR_TIMEOUT_MULT, 64'd255);
      // start just short of the 32-bit wrap
      run_random_phase(150, 32'hFFFF_FE00);
      wait_until_drained();

      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      write_csr(cfs_pkg::CSR_SLOT_ENABLE, 64'hF);
      write_csr(cfs_pkg::CSR_MESSAGE_IDS, {$urandom, $urandom});
      write_csr(cfs_pkg::CSR_PERIODS, {16'($urandom_range(40)), 16'($urandom_range(40)),
                                       16'($urandom_range(40)), 16'($urandom_range(40))});
      write_csr(cfs_pkg::CSR_CHECKSUM_LAYOUT, 64'hFFFF);
      write_csr(cfs_pkg::CSR_COUNTER_LAYOUT, 64'hFFF_FFFF);
      write_csr(cfs_pkg::CSR_TIMEOUT_MULT, 64'($urandom_range(254, 2)));
      stall_request <= 1'b1;
      run_random_phase(145, $urandom);
      wait_until_drained();

      $display("%0d requests accepted, %0d anomalies checked (gap %0d, checksum %0d,",
               accepted_count, anomaly_count, kind_hits[0], kind_hits[1]);
      $display("  unknown id %0d, timeout %0d) over four register setups and idle mixes",
               kind_hits[2], kind_hits[3]);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d failures", error_count);
         $display("== FAIL ==");
      end
      $finish;
   end

   // starve the response side so the core backs up into req_ready
   initial begin
      do @(posedge clock); while (!stall_request);
      long_hold <= 1'b1;
      repeat (300) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin
      #2000000;
      $display("timed out with %0d anomalies outstanding", expected_anomalies.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule

// File: files.f
src/cfs_pkg.sv
src/cfs_lane.sv
src/cfs_merge.sv
src/can_frame_supervisor_core.sv
src/cfs_checker.sv
test/tb_can_frame_supervisor_core.sv
